FILE: hw/rtl/ges_pkg.sv
// Shared types and constants for the graph edge store.
// No dependencies; imported by the top-level module.
package ges_pkg;

  // Default vertex capacity
  localparam int MAX_VERTICES_DEF = 32;

  // Fixed field widths
  localparam int VTX_W  = 6;
  localparam int TOT_W  = 10;
  localparam int FUNC_W = 2;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT   = 2'd0,
    FN_REMOVE   = 2'd1,
    FN_TEST     = 2'd2,
    FN_TRAVERSE = 2'd3
  } func_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LEN,
    S_SCAN,
    S_CMP,
    S_SHRD,
    S_SHWR,
    S_FIN,
    S_RESULT,
    S_TSTART,
    S_POP,
    S_POPD,
    S_NLEN,
    S_NRD,
    S_NCHK,
    S_TDONE
  } state_t;

endpackage

FILE: hw/rtl/graph_edge_store_with_stack_traversal.sv
// Edge operations scan the source vertex's list one entry at a time; a remove also moves
// each later entry up by one. Traverse walks the vertices with a stack, reading each list.
// One request at a time; busy is high meanwhile.
// Results appear for one cycle on done and cannot be stalled by the receiver.
// Synchronous reset clears list lengths (valid bits), edge total, visited marks and
// sets vertex_count to min(32, MAX_VERTICES); table and stack contents are undefined.
module graph_edge_store_with_stack_traversal
  import ges_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [FUNC_W-1:0] func,
  input  logic [VTX_W-1:0] from_vertex,
  input  logic [VTX_W-1:0] to_vertex,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [VTX_W-1:0] cfg_data,
  output logic             done,
  output logic             ok,
  output logic [VTX_W-1:0] visited_vertex,
  output logic [TOT_W-1:0] edge_total_now,
  output logic             last
);

  localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int LW = $clog2(MAX_VERTICES + 1);
  localparam int SW = $clog2(MAX_VERTICES + 2);
  localparam int CW = (SW > VTX_W) ? SW + 1 : VTX_W + 1;
  localparam int RST_N = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;

  // Control and payload registers
  state_t state, state_next;
  func_t              op;
  logic [VTX_W-1:0]   v_r;
  logic [IW-1:0]      row;
  logic [LW-1:0]      len_q;
  logic [LW-1:0]      idx;
  logic               found;
  logic               res_ok;
  logic [LW-1:0]      nv;
  logic [TOT_W-1:0]   tot;
  logic [MAX_VERTICES-1:0] visited;
  logic [SW-1:0]      s;
  logic [LW-1:0]      top;
  logic [VTX_W-1:0]   pend_vtx;

  // Memories
  logic [VTX_W-1:0] tbl_mem [MAX_VERTICES][MAX_VERTICES];
  logic [VTX_W-1:0] tbl_rdata;
  logic [LW-1:0]    len_mem [MAX_VERTICES];
  logic [LW-1:0]    len_mem_q;
  logic [MAX_VERTICES-1:0] len_vld;
  logic             len_vld_q;
  logic [VTX_W-1:0] stk_mem [MAX_VERTICES];
  logic [VTX_W-1:0] stk_rdata;

  // Memory controls
  logic             tbl_we;
  logic [IW-1:0]    tbl_wcol, tbl_rrow, tbl_rcol;
  logic [VTX_W-1:0] tbl_wdata;
  logic             len_we;
  logic [IW-1:0]    len_waddr, len_raddr;
  logic [LW-1:0]    len_wdata;
  logic             stk_we;
  logic [IW-1:0]    stk_waddr, stk_raddr;
  logic [VTX_W-1:0] stk_wdata;

  logic [LW-1:0]    len_rd;
  logic             args_ok;
  logic             push_ok;
  logic [IW-1:0]    w_idx;
  logic [IW-1:0]    s_idx;

  assign len_rd = len_vld_q ? len_mem_q : '0;
  assign s_idx  = IW'(s - SW'(1));
  assign w_idx  = IW'(tbl_rdata - VTX_W'(1));

  // Request argument check
  assign args_ok = (from_vertex != '0) && (to_vertex != '0) &&
                   (CW'(from_vertex) <= CW'(nv)) && (CW'(to_vertex) <= CW'(nv)) &&
                   (from_vertex != to_vertex);

  // Neighbour may be pushed during the walk
  assign push_ok = (tbl_rdata != '0) && (CW'(tbl_rdata) <= CW'(nv)) &&
                   !visited[w_idx] && (CW'(top) < CW'(MAX_VERTICES));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (func_t'(func) == FN_TRAVERSE) state_next = S_TSTART;
          else if (!args_ok)               state_next = S_RESULT;
          else                             state_next = S_LEN;
        end
      end
      S_LEN:    state_next = S_SCAN;
      S_SCAN:   state_next = (idx < len_q) ? S_CMP : S_FIN;
      S_CMP: begin
        if (tbl_rdata == v_r) state_next = (op == FN_REMOVE) ? S_SHRD : S_FIN;
        else                  state_next = S_SCAN;
      end
      S_SHRD:   state_next = (CW'(idx) + CW'(1) < CW'(len_q)) ? S_SHWR : S_FIN;
      S_SHWR:   state_next = S_SHRD;
      S_FIN:    state_next = S_RESULT;
      S_RESULT: state_next = S_IDLE;
      S_TSTART: begin
        if (CW'(s) > CW'(nv))  state_next = S_TDONE;
        else if (!visited[s_idx]) state_next = S_POP;
      end
      S_POP:    state_next = (top == '0) ? S_TSTART : S_POPD;
      S_POPD:   state_next = S_NLEN;
      S_NLEN:   state_next = S_NRD;
      S_NRD:    state_next = (idx == '0) ? S_POP : S_NCHK;
      S_NCHK:   state_next = S_NRD;
      S_TDONE:  state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs and memory controls
  always_comb begin
    busy      = (state != S_IDLE);
    cfg_ready = (state == S_IDLE);
    done      = (state == S_RESULT) || (state == S_TDONE) || (state == S_POPD && s != '0 &&
                pend_vtx != '0);
    ok        = (state == S_RESULT) ? res_ok : 1'b1;
    visited_vertex = (state == S_RESULT) ? '0 : pend_vtx;
    last      = (state == S_RESULT) || (state == S_TDONE);
    edge_total_now = tot;

    tbl_we    = 1'b0;
    tbl_wcol  = idx[IW-1:0];
    tbl_wdata = stk_rdata;
    tbl_rrow  = row;
    tbl_rcol  = idx[IW-1:0];
    len_we    = 1'b0;
    len_waddr = row;
    len_wdata = len_q;
    len_raddr = IW'(from_vertex - VTX_W'(1));
    stk_we    = 1'b0;
    stk_waddr = top[IW-1:0];
    stk_wdata = tbl_rdata;
    stk_raddr = IW'(top - LW'(1));

    case (state)
      S_SHRD: tbl_rcol = IW'(idx + LW'(1));
      S_SHWR: begin
        tbl_we    = 1'b1;
        tbl_wdata = tbl_rdata;
      end
      S_FIN: begin
        if (op == FN_INSERT && !found && CW'(len_q) < CW'(MAX_VERTICES)) begin
          tbl_we    = 1'b1;
          tbl_wcol  = len_q[IW-1:0];
          tbl_wdata = v_r;
          len_we    = 1'b1;
          len_wdata = len_q + LW'(1);
        end else if (op == FN_REMOVE && found) begin
          len_we    = 1'b1;
          len_wdata = len_q - LW'(1);
        end
      end
      S_TSTART: begin
        stk_we    = (CW'(s) <= CW'(nv)) && !visited[s_idx];
        stk_waddr = '0;
        stk_wdata = VTX_W'(s);
      end
      S_POPD:  len_raddr = IW'(stk_rdata - VTX_W'(1));
      S_NRD:   tbl_rcol  = IW'(idx - LW'(1));
      S_NCHK:  stk_we    = push_ok;
      default: ;
    endcase
  end

  // Neighbour table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[row][tbl_wcol] <= tbl_wdata;
    tbl_rdata <= tbl_mem[tbl_rrow][tbl_rcol];
  end

  // List lengths with per-entry valid bits
  always_ff @(posedge clk) begin
    if (len_we) len_mem[len_waddr] <= len_wdata;
    len_mem_q <= len_mem[len_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_vld   <= '0;
      len_vld_q <= 1'b0;
    end else begin
      if (len_we) len_vld[len_waddr] <= 1'b1;
      len_vld_q <= len_vld[len_raddr];
    end
  end

  // Walk stack
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_rdata <= stk_mem[stk_raddr];
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      nv       <= LW'(RST_N);
      tot      <= '0;
      visited  <= '0;
      s        <= '0;
      top      <= '0;
      pend_vtx <= '0;
    end else begin
      state <= state_next;

      // vertex_count write, clamped to 1..MAX_VERTICES
      if (cfg_valid && cfg_ready) begin
        if (cfg_data == '0)                          nv <= LW'(1);
        else if (CW'(cfg_data) > CW'(MAX_VERTICES)) nv <= LW'(MAX_VERTICES);
        else                                         nv <= LW'(cfg_data);
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            op     <= func_t'(func);
            v_r    <= to_vertex;
            row    <= IW'(from_vertex - VTX_W'(1));
            res_ok <= 1'b0;
            if (func_t'(func) == FN_TRAVERSE) begin
              visited  <= '0;
              s        <= SW'(1);
              top      <= '0;
              pend_vtx <= '0;
            end else begin
              s        <= '0;
            end
          end
        end
        S_LEN: begin
          len_q <= len_rd;
          idx   <= '0;
          found <= 1'b0;
        end
        S_CMP: begin
          if (tbl_rdata == v_r) found <= 1'b1;
          else                  idx   <= idx + LW'(1);
        end
        S_SHWR: idx <= idx + LW'(1);
        S_FIN: begin
          case (op)
            FN_INSERT: begin
              if (!found && CW'(len_q) < CW'(MAX_VERTICES)) begin
                tot    <= tot + TOT_W'(1);
                res_ok <= 1'b1;
              end
            end
            FN_REMOVE: begin
              if (found) begin
                tot    <= tot - TOT_W'(1);
                res_ok <= 1'b1;
              end
            end
            default: res_ok <= found;
          endcase
        end
        S_TSTART: begin
          if (CW'(s) <= CW'(nv)) begin
            if (visited[s_idx]) s <= s + SW'(1);
            else begin
              visited[s_idx] <= 1'b1;
              top            <= LW'(1);
            end
          end
        end
        S_POP: begin
          if (top == '0) s <= s + SW'(1);
          else           top <= top - LW'(1);
        end
        S_POPD: begin
          pend_vtx <= stk_rdata;
          row      <= IW'(stk_rdata - VTX_W'(1));
        end
        S_NLEN: idx <= len_rd;
        S_NCHK: begin
          if (push_ok) begin
            visited[w_idx] <= 1'b1;
            top            <= top + LW'(1);
          end
          idx <= idx - LW'(1);
        end
        default: ;
      endcase
    end
  end

  // Checks
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request not taken");
  a_tot_stable: assert property (@(posedge clk) disable iff (rst)
    state != S_FIN |=> tot == $past(tot)) else $error("edge total moved outside update");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    done && last |=> !busy) else $error("busy after final result");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result while idle");

endmodule
